[rtl/grid_ray_traversal_defines.svh]
// ----------------------------------------------------------------------------
// Grid ray traversal assertion macros
// Shared property wrappers for the checker of the tile map ray caster.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_TRAVERSAL_DEFINES_SVH
`define GRID_RAY_TRAVERSAL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GRT_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("grid ray traversal check failed");

// The consequent must hold in the cycle after the antecedent.
`define GRT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("grid ray traversal check failed");

`endif

[rtl/grt_pkg.sv]
// ----------------------------------------------------------------------------
// Grid ray traversal package
// Types, field widths and codes shared by the ray caster modules.
// ----------------------------------------------------------------------------
`default_nettype none

package grt_pkg;

    localparam int POS_W   = 22;
    localparam int DIR_W   = 21;
    localparam int SCALE_W = 24;
    localparam int DIST_W  = 32;
    localparam int CELL_W  = 8;
    localparam int VAL_W   = 8;
    localparam int IDX_W   = 12;
    localparam int FACE_W  = 2;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 1;
    localparam int DELTA_W = 48;

    localparam logic [DELTA_W-1:0] DELTA_MAX = {DELTA_W{1'b1}};
    localparam logic [CFG_W-1:0]   CFG_DIM_RESET = 7'd64;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;

    localparam logic [FACE_W-1:0] FACE_EAST  = 2'd0;
    localparam logic [FACE_W-1:0] FACE_WEST  = 2'd1;
    localparam logic [FACE_W-1:0] FACE_SOUTH = 2'd2;
    localparam logic [FACE_W-1:0] FACE_NORTH = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_CMP,
        ST_ADD,
        ST_CHK,
        ST_HIT,
        ST_DONE
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

`default_nettype wire

[rtl/grt_alu.sv]
// ----------------------------------------------------------------------------
// Grid ray traversal shared adder
// One wide add or subtract with carry out, reused for division, scaling,
// side distance compares and side distance accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module grt_alu
    import grt_pkg::*;
#(
    parameter int W = 64
) (
    input  t_alu_op        i_op,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic [W-1:0]   o_sum,
    output logic           o_carry
);

    logic [W-1:0] b_eff;
    logic [W:0]   full;

    always_comb begin
        case (i_op)
            ALU_SUB: b_eff = ~i_b;
            default: b_eff = i_b;
        endcase
    end

    // On a subtract the carry out is set when a is not below b.
    assign full    = {1'b0, i_a} + {1'b0, b_eff} + {{W{1'b0}}, (i_op == ALU_SUB)};
    assign o_sum   = full[W-1:0];
    assign o_carry = full[W];

endmodule

`default_nettype wire

[rtl/grt_map.sv]
// ----------------------------------------------------------------------------
// Grid ray traversal tile map
// Single write port, single registered read port store of wall types.
// ----------------------------------------------------------------------------
`default_nettype none

module grt_map
    import grt_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [VAL_W-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/grid_ray_traversal.sv]
// Cell write: accepted while idle, no result.
// Ray cast: two serial divisions on the shared adder, then the serial start scaling,
// then per cell step the compare, add, check and hit states (the hit state is skipped
// for the last step when the ray leaves the map), then the done state hands over.
// One request at a time; synchronous active low reset, then a clearing pass over all
// MAP_MAX_WIDTH*MAP_MAX_HEIGHT cells (4096 by default) before the first request.
// ----------------------------------------------------------------------------
// Grid ray traversal
// Tile map store and DDA grid ray caster built around one shared adder.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_ray_traversal
    import grt_pkg::*;
#(
    parameter int MAP_MAX_WIDTH  = 64,
    parameter int MAP_MAX_HEIGHT = 64,
    parameter int FRAC_BITS      = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_op,
    input  logic [IDX_W-1:0]         i_cell_index,
    input  logic [VAL_W-1:0]         i_cell_value,
    input  logic [POS_W-1:0]         i_start_x,
    input  logic [POS_W-1:0]         i_start_y,
    input  logic signed [DIR_W-1:0]  i_dir_x,
    input  logic signed [DIR_W-1:0]  i_dir_y,
    input  logic [SCALE_W-1:0]       i_ray_scale,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [DIST_W-1:0]        o_distance,
    output logic signed [CELL_W-1:0] o_cell_x,
    output logic signed [CELL_W-1:0] o_cell_y,
    output logic [VAL_W-1:0]         o_wall_type,
    output logic [FACE_W-1:0]        o_face
);

    localparam int MAP_CELLS  = MAP_MAX_WIDTH * MAP_MAX_HEIGHT;
    localparam int AW         = $clog2(MAP_CELLS);
    localparam int STEP_LIMIT = MAP_MAX_WIDTH + MAP_MAX_HEIGHT + 2;
    localparam int STEP_W     = $clog2(STEP_LIMIT + 1);
    localparam int SIDE_W     = DELTA_W + $clog2(STEP_LIMIT + 2);
    localparam int NUM_W      = SCALE_W + FRAC_BITS;
    localparam int CNT_W      = $clog2(NUM_W + 1);
    localparam int SX_W       = (POS_W > FRAC_BITS) ? POS_W : FRAC_BITS + 1;
    localparam int SI_W       = (POS_W > FRAC_BITS) ? POS_W - FRAC_BITS : 1;
    localparam int CX_W       = ((SI_W > STEP_W) ? SI_W : STEP_W) + 2;
    localparam int WD_W       = $clog2(MAP_MAX_WIDTH + 1);
    localparam int HD_W       = $clog2(MAP_MAX_HEIGHT + 1);
    localparam int LIN_W      = WD_W + HD_W;
    localparam int F_W        = FRAC_BITS + 1;

    localparam logic [F_W-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_map_width, r_map_height;
    logic [AW-1:0]    r_clr;

    logic               r_axis;
    logic [CNT_W-1:0]   r_cnt;
    logic [NUM_W-1:0]   r_num;
    logic [NUM_W-1:0]   r_quo;
    logic [DIR_W-1:0]   r_rem;
    logic [SCALE_W-1:0] r_scale;
    logic [DIR_W-1:0]   r_mag_x, r_mag_y;
    logic               r_neg_x, r_neg_y;
    logic [DELTA_W-1:0] r_dx, r_dy;
    logic [F_W-1:0]     r_fx, r_fy;
    logic [SIDE_W-1:0]  r_acc;
    logic [SIDE_W-1:0]  r_side_x, r_side_y;
    logic [SIDE_W-1:0]  r_dist;
    logic               r_side;
    logic signed [CX_W-1:0] r_cx, r_cy;
    logic [WD_W-1:0]    r_w;
    logic [HD_W-1:0]    r_h;
    logic [STEP_W-1:0]  r_steps;
    logic [VAL_W-1:0]   r_hit;

    logic                     r_out_valid;
    logic [DIST_W-1:0]        r_o_distance;
    logic signed [CELL_W-1:0] r_o_cell_x, r_o_cell_y;
    logic [VAL_W-1:0]         r_o_wall_type;
    logic [FACE_W-1:0]        r_o_face;

    t_alu_op           alu_op;
    logic [SIDE_W-1:0] alu_a, alu_b, alu_sum;
    logic              alu_carry;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [VAL_W-1:0] mem_rdata;

    logic              in_fire, out_fire, load_out;
    logic              clr_last, div_last, mul_last, step_last, outside;
    logic [DIR_W:0]    div_t;
    logic [DIR_W-1:0]  mag_sel;
    logic [DELTA_W-1:0] d_sel;
    logic [NUM_W-1:0]  quo_fin;
    logic [DELTA_W-1:0] delta_fin;
    logic [LIN_W-1:0]  lin;

    logic [DIR_W-1:0]  dx_raw, dy_raw, mag_x_in, mag_y_in;
    logic [SX_W-1:0]   sx_ext, sy_ext;
    logic [F_W-1:0]    fx_in, fy_in;
    logic [WD_W-1:0]   w_eff;
    logic [HD_W-1:0]   h_eff;

    // Request side decode.
    assign dx_raw   = i_dir_x;
    assign dy_raw   = i_dir_y;
    assign mag_x_in = dx_raw[DIR_W-1] ? (~dx_raw + DIR_W'(1)) : dx_raw;
    assign mag_y_in = dy_raw[DIR_W-1] ? (~dy_raw + DIR_W'(1)) : dy_raw;
    assign sx_ext   = SX_W'(i_start_x);
    assign sy_ext   = SX_W'(i_start_y);
    assign fx_in    = dx_raw[DIR_W-1] ? {1'b0, sx_ext[FRAC_BITS-1:0]}
                                      : FRAC_ONE - {1'b0, sx_ext[FRAC_BITS-1:0]};
    assign fy_in    = dy_raw[DIR_W-1] ? {1'b0, sy_ext[FRAC_BITS-1:0]}
                                      : FRAC_ONE - {1'b0, sy_ext[FRAC_BITS-1:0]};

    always_comb begin
        if (r_map_width == '0) begin
            w_eff = WD_W'(1);
        end else if (32'(r_map_width) > MAP_MAX_WIDTH) begin
            w_eff = WD_W'(MAP_MAX_WIDTH);
        end else begin
            w_eff = WD_W'(r_map_width);
        end
        if (r_map_height == '0) begin
            h_eff = HD_W'(1);
        end else if (32'(r_map_height) > MAP_MAX_HEIGHT) begin
            h_eff = HD_W'(MAP_MAX_HEIGHT);
        end else begin
            h_eff = HD_W'(r_map_height);
        end
    end

    // Shared datapath terms.
    assign mag_sel   = r_axis ? r_mag_y : r_mag_x;
    assign d_sel     = (r_axis ? r_side : 1'b0) ? r_dy : r_dx;
    assign div_t     = {r_rem, r_num[NUM_W-1]};
    assign quo_fin   = {r_quo[NUM_W-2:0], alu_carry};
    assign delta_fin = (mag_sel == '0) ? DELTA_MAX : DELTA_W'(quo_fin);
    assign div_last  = (r_cnt == CNT_W'(NUM_W - 1));
    assign mul_last  = (r_cnt == CNT_W'(FRAC_BITS));
    assign step_last = (r_steps == STEP_W'(STEP_LIMIT - 1));
    assign clr_last  = (r_clr == AW'(MAP_CELLS - 1));
    assign outside   = (r_cx < 0) || (r_cy < 0)
                    || (r_cx >= $signed(CX_W'(r_w))) || (r_cy >= $signed(CX_W'(r_h)));
    assign lin       = LIN_W'(r_w) * LIN_W'(r_cy[HD_W-1:0]) + LIN_W'(r_cx[WD_W-1:0]);

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = r_out_valid && i_out_ready;
    assign load_out = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (clr_last) n_state = ST_IDLE;
            ST_IDLE:  if (in_fire && i_op == OP_CAST) n_state = ST_DIV;
            ST_DIV:   if (div_last && r_axis) n_state = ST_MUL;
            ST_MUL:   if (mul_last && r_axis) n_state = ST_CMP;
            ST_CMP:   n_state = ST_ADD;
            ST_ADD:   n_state = ST_CHK;
            ST_CHK:   n_state = outside ? ST_DONE : ST_HIT;
            ST_HIT:   n_state = (mem_rdata != '0 || step_last) ? ST_DONE : ST_CMP;
            ST_DONE:  if (load_out) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_in_ready = 1'b0;
        alu_op     = ALU_ADD;
        alu_a      = '0;
        alu_b      = '0;
        mem_we     = 1'b0;
        mem_waddr  = AW'(i_cell_index);
        mem_wdata  = i_cell_value;
        mem_raddr  = AW'(lin);
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                mem_we     = i_in_valid && i_op == OP_WRITE
                          && 32'(i_cell_index) < MAP_CELLS;
            end
            ST_DIV: begin
                alu_op = ALU_SUB;
                alu_a  = SIDE_W'(div_t);
                alu_b  = SIDE_W'(mag_sel);
            end
            ST_MUL: begin
                alu_a = r_acc;
                alu_b = (r_axis ? r_fy[0] : r_fx[0]) ? SIDE_W'(r_axis ? r_dy : r_dx) : '0;
            end
            ST_CMP: begin
                alu_op = ALU_SUB;
                alu_a  = r_side_y;
                alu_b  = r_side_x;
            end
            ST_ADD: begin
                alu_a = r_side ? r_side_y : r_side_x;
                alu_b = SIDE_W'(d_sel);
            end
            default: begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    grt_alu #(
        .W (SIDE_W)
    ) u_alu (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    grt_map #(
        .DEPTH (MAP_CELLS),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_map_width  <= CFG_DIM_RESET;
            r_map_height <= CFG_DIM_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MAP_WIDTH:  r_map_width  <= i_cfg_data;
                    REG_MAP_HEIGHT: r_map_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_axis  <= 1'b0;
                r_cnt   <= '0;
                r_num   <= {i_ray_scale, {FRAC_BITS{1'b0}}};
                r_rem   <= '0;
                r_scale <= i_ray_scale;
                r_mag_x <= mag_x_in;
                r_mag_y <= mag_y_in;
                r_neg_x <= dx_raw[DIR_W-1];
                r_neg_y <= dy_raw[DIR_W-1];
                r_fx    <= fx_in;
                r_fy    <= fy_in;
                r_cx    <= $signed(CX_W'(SI_W'(sx_ext >> FRAC_BITS)));
                r_cy    <= $signed(CX_W'(SI_W'(sy_ext >> FRAC_BITS)));
                r_w     <= w_eff;
                r_h     <= h_eff;
                r_steps <= '0;
                r_side  <= 1'b0;
            end
            ST_DIV: begin
                r_quo <= quo_fin;
                if (div_last) begin
                    r_cnt <= '0;
                    if (r_axis) begin
                        r_dy   <= delta_fin;
                        r_axis <= 1'b0;
                        r_acc  <= '0;
                    end else begin
                        r_dx   <= delta_fin;
                        r_axis <= 1'b1;
                        r_num  <= {r_scale, {FRAC_BITS{1'b0}}};
                        r_rem  <= '0;
                    end
                end else begin
                    r_rem <= alu_carry ? alu_sum[DIR_W-1:0] : div_t[DIR_W-1:0];
                    r_num <= {r_num[NUM_W-2:0], 1'b0};
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            ST_MUL: begin
                if (r_axis) begin
                    r_fy <= r_fy >> 1;
                end else begin
                    r_fx <= r_fx >> 1;
                end
                if (mul_last) begin
                    r_cnt <= '0;
                    r_acc <= '0;
                    if (r_axis) begin
                        r_side_y <= alu_sum;
                    end else begin
                        r_side_x <= alu_sum;
                        r_axis   <= 1'b1;
                    end
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    r_acc <= alu_sum >> 1;
                end
            end
            ST_CMP: begin
                // The x crossing wins a tie.
                r_side <= ~alu_carry;
            end
            ST_ADD: begin
                if (r_side) begin
                    r_dist   <= r_side_y;
                    r_side_y <= alu_sum;
                    r_cy     <= r_neg_y ? r_cy - CX_W'(1) : r_cy + CX_W'(1);
                end else begin
                    r_dist   <= r_side_x;
                    r_side_x <= alu_sum;
                    r_cx     <= r_neg_x ? r_cx - CX_W'(1) : r_cx + CX_W'(1);
                end
            end
            ST_CHK: begin
                r_hit <= '0;
            end
            ST_HIT: begin
                r_hit   <= mem_rdata;
                r_steps <= r_steps + STEP_W'(1);
            end
            default: ;
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_distance  <= (|r_dist[SIDE_W-1:DIST_W]) ? {DIST_W{1'b1}}
                                                         : r_dist[DIST_W-1:0];
            r_o_cell_x    <= CELL_W'(r_cx);
            r_o_cell_y    <= CELL_W'(r_cy);
            r_o_wall_type <= r_hit;
            if (r_side) begin
                r_o_face <= (!r_neg_y && r_mag_y != '0) ? FACE_SOUTH : FACE_NORTH;
            end else begin
                r_o_face <= (!r_neg_x && r_mag_x != '0) ? FACE_EAST : FACE_WEST;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_o_distance;
    assign o_cell_x    = r_o_cell_x;
    assign o_cell_y    = r_o_cell_y;
    assign o_wall_type = r_o_wall_type;
    assign o_face      = r_o_face;

endmodule

`default_nettype wire

[rtl/grt_checker.sv]
// ----------------------------------------------------------------------------
// Grid ray traversal port checker
// Watches the request and result channels of the ray caster.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_ray_traversal_defines.svh"

module grt_checker
    import grt_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              i_op,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [DIST_W-1:0] o_distance,
    input logic [VAL_W-1:0]  o_wall_type,
    input logic [FACE_W-1:0] o_face
);

    `GRT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `GRT_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_distance) && $stable(o_wall_type) && $stable(o_face))
    `GRT_ASSERT_NEXT(a_cast_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && i_op == OP_CAST, !o_in_ready)
    `GRT_ASSERT_NEXT(a_write_silent, i_clk, i_rst_n, i_in_valid && o_in_ready && i_op == OP_WRITE && !o_out_valid, !o_out_valid)

endmodule

bind grid_ray_traversal grt_checker u_grt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_op        (i_op),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_distance  (o_distance),
    .o_wall_type (o_wall_type),
    .o_face      (o_face)
);

`default_nettype wire

[tb/grid_ray_traversal_checker.sv]
// ----------------------------------------------------------------------------
// Grid ray traversal checker
// Watches the request, configuration and result ports of the ray caster. It
// keeps its own copy of the tile map and the map size, traces every accepted
// cast cell by cell, and compares each result field with the oldest pending
// trace.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_ray_traversal_checker
    import grt_pkg::*;
#(
    parameter int MAP_MAX_WIDTH  = 64,
    parameter int MAP_MAX_HEIGHT = 64,
    parameter int FRAC_BITS      = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic                     i_op,
    input  logic [IDX_W-1:0]         i_cell_index,
    input  logic [VAL_W-1:0]         i_cell_value,
    input  logic [POS_W-1:0]         i_start_x,
    input  logic [POS_W-1:0]         i_start_y,
    input  logic [DIR_W-1:0]         i_dir_x,
    input  logic [DIR_W-1:0]         i_dir_y,
    input  logic [SCALE_W-1:0]       i_ray_scale,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic [DIST_W-1:0]        i_distance,
    input  logic signed [CELL_W-1:0] i_cell_x,
    input  logic signed [CELL_W-1:0] i_cell_y,
    input  logic [VAL_W-1:0]         i_wall_type,
    input  logic [FACE_W-1:0]        i_face,
    output int                       o_fail_count,
    output int                       o_pending
);

    localparam int          MAP_CELLS    = MAP_MAX_WIDTH * MAP_MAX_HEIGHT;
    localparam int          STEP_LIMIT   = MAP_MAX_WIDTH + MAP_MAX_HEIGHT + 2;
    localparam logic [63:0] FRAC_ONE     = 64'd1 << FRAC_BITS;
    localparam logic [63:0] FRAC_MASK    = FRAC_ONE - 64'd1;

    typedef struct packed {
        logic [DIST_W-1:0]        distance;
        logic signed [CELL_W-1:0] cell_x;
        logic signed [CELL_W-1:0] cell_y;
        logic [VAL_W-1:0]         wall_code;
        logic [FACE_W-1:0]        face;
    } t_ray_hit;

    logic [VAL_W-1:0] tile_map [MAP_CELLS];
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    t_ray_hit         rays_in_flight [$];
    t_ray_hit         oldest_hit;

    function automatic int used_dim(input logic [CFG_W-1:0] v, input int max_dim);
        if (v == '0) begin
            return 1;
        end
        return (int'(v) > max_dim) ? max_dim : int'(v);
    endfunction

    function automatic logic [63:0] dir_magnitude(input logic [DIR_W-1:0] raw);
        return raw[DIR_W-1] ? (64'd1 << DIR_W) - 64'(raw) : 64'(raw);
    endfunction

    function automatic logic [63:0] step_span(input logic [SCALE_W-1:0] scale,
                                              input logic [63:0] mag);
        logic [63:0] q;
        if (mag == 64'd0) begin
            return 64'(DELTA_MAX);
        end
        q = (64'(scale) << FRAC_BITS) / mag;
        return (q > 64'(DELTA_MAX)) ? 64'(DELTA_MAX) : q;
    endfunction

    function automatic logic [63:0] frac_scale(input logic [63:0] f, input logic [63:0] d);
        return (d >> FRAC_BITS) * f + (((d & FRAC_MASK) * f) >> FRAC_BITS);
    endfunction

    function automatic t_ray_hit trace_ray(input logic [POS_W-1:0] sx,
                                           input logic [POS_W-1:0] sy,
                                           input logic [DIR_W-1:0] raw_x,
                                           input logic [DIR_W-1:0] raw_y,
                                           input logic [SCALE_W-1:0] scale);
        int               w, h, cx, cy, steps;
        logic [63:0]      mag_x, mag_y, span_x, span_y, side_x, side_y, fx, fy, travel;
        logic             neg_x, neg_y, on_y, left_map;
        logic [VAL_W-1:0] wall;
        t_ray_hit         r;
        w = used_dim(width_reg, MAP_MAX_WIDTH);
        h = used_dim(height_reg, MAP_MAX_HEIGHT);
        neg_x = raw_x[DIR_W-1];
        neg_y = raw_y[DIR_W-1];
        mag_x = dir_magnitude(raw_x);
        mag_y = dir_magnitude(raw_y);
        span_x = step_span(scale, mag_x);
        span_y = step_span(scale, mag_y);
        cx = int'(sx >> FRAC_BITS);
        cy = int'(sy >> FRAC_BITS);
        fx = 64'(sx) & FRAC_MASK;
        fy = 64'(sy) & FRAC_MASK;
        side_x = frac_scale(neg_x ? fx : FRAC_ONE - fx, span_x);
        side_y = frac_scale(neg_y ? fy : FRAC_ONE - fy, span_y);
        on_y = 1'b0;
        left_map = 1'b0;
        wall = '0;
        // Ties go to the x crossing.
        for (steps = 0; steps < STEP_LIMIT && wall == '0 && !left_map; steps++) begin
            if (side_x > side_y) begin
                cy = neg_y ? cy - 1 : cy + 1;
                side_y = side_y + span_y;
                on_y = 1'b1;
            end else begin
                cx = neg_x ? cx - 1 : cx + 1;
                side_x = side_x + span_x;
                on_y = 1'b0;
            end
            if (cx < 0 || cy < 0 || cx >= w || cy >= h) begin
                left_map = 1'b1;
            end else begin
                wall = tile_map[cx + w * cy];
            end
        end
        travel = on_y ? side_y - span_y : side_x - span_x;
        r.distance = (travel > 64'hFFFF_FFFF) ? '1 : travel[DIST_W-1:0];
        r.cell_x = cx[CELL_W-1:0];
        r.cell_y = cy[CELL_W-1:0];
        r.wall_code = wall;
        if (on_y) begin
            r.face = (!neg_y && mag_y != 64'd0) ? FACE_SOUTH : FACE_NORTH;
        end else begin
            r.face = (!neg_x && mag_x != 64'd0) ? FACE_EAST : FACE_WEST;
        end
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            o_fail_count = o_fail_count + 1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (tile_map[i]) begin
                tile_map[i] = '0;
            end
            width_reg = CFG_DIM_RESET;
            height_reg = CFG_DIM_RESET;
            rays_in_flight.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_MAP_WIDTH) begin
                    width_reg = i_cfg_data;
                end else begin
                    height_reg = i_cfg_data;
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_op == OP_WRITE) begin
                    if (int'(i_cell_index) < MAP_CELLS) begin
                        tile_map[i_cell_index] = i_cell_value;
                    end
                end else begin
                    rays_in_flight.push_back(trace_ray(i_start_x, i_start_y, i_dir_x,
                                                       i_dir_y, i_ray_scale));
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (rays_in_flight.size() == 0) begin
                    $display("%0t: result with no cast pending, expected none, got distance %0h",
                             $time, i_distance);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    oldest_hit = rays_in_flight.pop_front();
                    check_field("distance", oldest_hit.distance, i_distance);
                    check_field("cell_x", 32'(oldest_hit.cell_x), 32'(i_cell_x));
                    check_field("cell_y", 32'(oldest_hit.cell_y), 32'(i_cell_y));
                    check_field("wall code", 32'(oldest_hit.wall_code), 32'(i_wall_type));
                    check_field("face", 32'(oldest_hit.face), 32'(i_face));
                end
            end
        end
        o_pending = rays_in_flight.size();
    end

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Grid ray traversal testbench
// Drives cell writes and ray casts into the ray caster under several map
// sizes, with random idle bursts on both handshakes, and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import grt_pkg::*;

    localparam int MAP_DIM        = 64;
    localparam int FRAC_BITS      = 16;
    localparam int ONE            = 1 << FRAC_BITS;
    localparam int HALF           = ONE / 2;
    localparam int QUARTER        = ONE / 4;
    localparam int PHASE_ITEMS    = 130;
    localparam int WATCHDOG_LIMIT = 20000;

    localparam logic [DIR_W-1:0] DIR_ONE     = 21'h010000;
    localparam logic [DIR_W-1:0] DIR_NEG_ONE = 21'h1F0000;
    localparam logic [DIR_W-1:0] DIR_POS_MAX = 21'h0FFFFF;
    localparam logic [DIR_W-1:0] DIR_NEG_MAX = 21'h100000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]         cfg_data = '0;
    logic                     in_valid = 1'b0;
    wire                      in_ready;
    logic                     op = OP_WRITE;
    logic [IDX_W-1:0]         cell_index = '0;
    logic [VAL_W-1:0]         cell_value = '0;
    logic [POS_W-1:0]         start_x = '0;
    logic [POS_W-1:0]         start_y = '0;
    logic [DIR_W-1:0]         dir_x = '0;
    logic [DIR_W-1:0]         dir_y = '0;
    logic [SCALE_W-1:0]       ray_scale = '0;
    wire                      out_valid;
    logic                     out_ready = 1'b0;
    wire [DIST_W-1:0]         distance;
    wire signed [CELL_W-1:0]  cell_x;
    wire signed [CELL_W-1:0]  cell_y;
    wire [VAL_W-1:0]          wall_code;
    wire [FACE_W-1:0]         face;

    int fail_count;
    int pending;
    int eff_w = MAP_DIM;
    int eff_h = MAP_DIM;
    int stall_left = 0;
    int quiet_cycles = 0;
    int phase;
    bit tx_gaps = 1'b1;
    bit rx_stalls = 1'b1;

    grid_ray_traversal dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_op         (op),
        .i_cell_index (cell_index),
        .i_cell_value (cell_value),
        .i_start_x    (start_x),
        .i_start_y    (start_y),
        .i_dir_x      (dir_x),
        .i_dir_y      (dir_y),
        .i_ray_scale  (ray_scale),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_distance   (distance),
        .o_cell_x     (cell_x),
        .o_cell_y     (cell_y),
        .o_wall_type  (wall_code),
        .o_face       (face)
    );

    grid_ray_traversal_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_op         (op),
        .i_cell_index (cell_index),
        .i_cell_value (cell_value),
        .i_start_x    (start_x),
        .i_start_y    (start_y),
        .i_dir_x      (dir_x),
        .i_dir_y      (dir_y),
        .i_ray_scale  (ray_scale),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_distance   (distance),
        .i_cell_x     (cell_x),
        .i_cell_y     (cell_y),
        .i_wall_type  (wall_code),
        .i_face       (face),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 clk = ~clk;

    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rx_stalls && $urandom_range(0, 9) == 0) begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("grid_ray_traversal test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [POS_W-1:0] fixed_pos(input int whole, input int frac);
        return POS_W'(whole * ONE + frac);
    endfunction

    function automatic logic [DIR_W-1:0] random_dir();
        logic [DIR_W-1:0] mag;
        int               pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return '0;
        end
        if (pick < 7) begin
            mag = DIR_W'($urandom_range(1, 2 * ONE));
            return $urandom_range(0, 1) ? -mag : mag;
        end
        return DIR_W'($urandom);
    endfunction

    // The request is held until accepted; the task returns on the following falling edge.
    task automatic drive_request(input logic kind, input logic [IDX_W-1:0] idx,
                                 input logic [VAL_W-1:0] val,
                                 input logic [POS_W-1:0] sx, input logic [POS_W-1:0] sy,
                                 input logic [DIR_W-1:0] dx, input logic [DIR_W-1:0] dy,
                                 input logic [SCALE_W-1:0] sc);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= kind;
        cell_index <= idx;
        cell_value <= val;
        start_x <= sx;
        start_y <= sy;
        dir_x <= dx;
        dir_y <= dy;
        ray_scale <= sc;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_cell(input int idx, input int val);
        drive_request(OP_WRITE, IDX_W'(idx), VAL_W'(val), POS_W'($urandom), POS_W'($urandom),
                      DIR_W'($urandom), DIR_W'($urandom), SCALE_W'($urandom));
    endtask

    task automatic cast_ray(input logic [POS_W-1:0] sx, input logic [POS_W-1:0] sy,
                            input logic [DIR_W-1:0] dx, input logic [DIR_W-1:0] dy,
                            input logic [SCALE_W-1:0] sc);
        drive_request(OP_CAST, IDX_W'($urandom), VAL_W'($urandom), sx, sy, dx, dy, sc);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic set_dims(input int w, input int h);
        wait_for_results();
        repeat (16) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_MAP_WIDTH;
        cfg_data <= CFG_W'(w);
        @(negedge clk);
        cfg_index <= REG_MAP_HEIGHT;
        cfg_data <= CFG_W'(h);
        @(negedge clk);
        cfg_we <= 1'b0;
        eff_w = (w == 0) ? 1 : ((w > MAP_DIM) ? MAP_DIM : w);
        eff_h = (h == 0) ? 1 : ((h > MAP_DIM) ? MAP_DIM : h);
    endtask

    task automatic random_request();
        logic [POS_W-1:0]   sx, sy;
        logic [SCALE_W-1:0] sc;
        int                 idx, val, pick;
        if ($urandom_range(0, 99) < 45) begin
            if ($urandom_range(0, 99) < 85) begin
                idx = $urandom_range(0, eff_w - 1) + eff_w * $urandom_range(0, eff_h - 1);
            end else begin
                idx = $urandom_range(0, 4095);
            end
            val = ($urandom_range(0, 99) < 55) ? 0 : $urandom_range(1, 255);
            write_cell(idx, val);
        end else begin
            if ($urandom_range(0, 4) != 0) begin
                sx = {6'($urandom_range(0, eff_w - 1)), 16'($urandom)};
                sy = {6'($urandom_range(0, eff_h - 1)), 16'($urandom)};
            end else begin
                sx = POS_W'($urandom);
                sy = POS_W'($urandom);
            end
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                sc = SCALE_W'(ONE);
            end else if (pick < 8) begin
                sc = SCALE_W'($urandom_range(0, 24'h3FFFF));
            end else begin
                sc = SCALE_W'($urandom);
            end
            cast_ray(sx, sy, random_dir(), random_dir(), sc);
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_cell(3, 8'hFF);
        write_cell(4095, 8'h80);
        write_cell(10 + MAP_DIM * 5, 8'h01);
        cast_ray(fixed_pos(0, HALF), fixed_pos(0, HALF), DIR_ONE, '0, SCALE_W'(ONE));
        cast_ray(fixed_pos(60, QUARTER), fixed_pos(63, HALF), DIR_ONE, '0, SCALE_W'(ONE));
        cast_ray(fixed_pos(20, HALF), fixed_pos(5, HALF), DIR_NEG_ONE, '0, SCALE_W'(ONE));
        cast_ray(fixed_pos(10, HALF), fixed_pos(0, HALF), '0, DIR_ONE, SCALE_W'(ONE));
        cast_ray(fixed_pos(3, HALF), fixed_pos(10, QUARTER), '0, DIR_NEG_ONE, SCALE_W'(ONE));
        // Both components zero: saturated steps that alternate between the axes, x first.
        cast_ray(fixed_pos(5, HALF), fixed_pos(5, HALF), '0, '0, SCALE_W'(ONE));
        // A diagonal from a cell center gives equal side distances.
        cast_ray(fixed_pos(30, HALF), fixed_pos(30, HALF), DIR_ONE, DIR_ONE, SCALE_W'(ONE));
        cast_ray('1, '1, DIR_NEG_MAX, DIR_POS_MAX, '1);
        cast_ray('0, '0, DIR_NEG_MAX, DIR_NEG_MAX, '0);
        cast_ray(fixed_pos(0, 0), fixed_pos(0, 0), DIR_ONE, DIR_ONE, '0);
        cast_ray(fixed_pos(1, 0), fixed_pos(62, 0), DIR_POS_MAX, 21'h000001, SCALE_W'(ONE));
        write_cell(4095, 8'h00);
        write_cell(0, 8'h00);
        cast_ray(fixed_pos(63, HALF), fixed_pos(63, HALF), DIR_NEG_ONE, DIR_NEG_ONE,
                 SCALE_W'(ONE));
        cast_ray(fixed_pos(8, HALF), fixed_pos(0, QUARTER), DIR_NEG_ONE, '0, SCALE_W'(ONE));

        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_dims(0, 0);
                1: set_dims(127, 127);
                2: set_dims(1, 64);
                3: set_dims(64, 1);
                4: set_dims(16, 9);
                5: set_dims(65, 40);
                6: set_dims(7, 33);
                default: set_dims(64, 64);
            endcase
            tx_gaps = (phase != 3 && phase != 7);
            rx_stalls = (phase != 7);
            repeat (PHASE_ITEMS) random_request();
        end

        wait_for_results();
        repeat (64) @(negedge clk);
        if (fail_count == 0) begin
            $display("grid_ray_traversal test passed");
        end else begin
            $display("grid_ray_traversal test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
